>>> hdl/cset_pkg.sv
`default_nettype none

package cset_pkg;

    localparam int DEF_MAX_FUNCS   = 256;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int OUTQ_DEPTH      = 3;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_END   = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  func_id;
        logic [31:0] timestamp;
    } cset_in_t;

    typedef struct packed {
        logic [7:0]  ended_id;
        logic [31:0] span_ticks;
        logic [31:0] exclusive_ticks;
        logic [31:0] running_total;
        status_t     status;
    } cset_out_t;

    typedef struct packed {
        logic [7:0]  func;
        logic [31:0] start;
        logic [31:0] child;
    } stk_entry_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [7:0]  fid;
        logic [31:0] span;
        logic [31:0] excl;
    } pop_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/cset_ram.sv
`default_nettype none

module cset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/cset_stack.sv
`default_nettype none

module cset_stack
    import cset_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     take,
    input  wire cset_in_t req,
    output pop_t          pop
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // top two entries live in registers, the rest in the ram
    logic [LW-1:0] level_reg, level_next;
    stk_entry_t    t0_reg, t0_next;
    stk_entry_t    t1_reg, t1_next;
    logic          pend_reg, pend_next;

    stk_entry_t    t1_eff;
    stk_entry_t    ram_wdata;
    stk_entry_t    ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;

    logic          is_full;
    logic          is_empty;
    logic [31:0]   diff;
    logic [31:0]   span;
    logic [31:0]   excl;
    logic [LW-1:0] lvl_m2;
    logic [LW-1:0] lvl_m3;

    always_comb
    begin
        t1_eff   = pend_reg ? ram_rdata : t1_reg;
        is_full  = (level_reg == LW'(STACK_DEPTH));
        is_empty = (level_reg == '0);
        diff     = req.timestamp - t0_reg.start;
        span     = (&diff) ? 32'hFFFF_FFFF : diff + 32'd1;
        excl     = (t0_reg.child <= span) ? span - t0_reg.child : 32'd0;
        lvl_m2   = level_reg - LW'(2);
        lvl_m3   = level_reg - LW'(3);

        level_next = level_reg;
        t0_next    = t0_reg;
        t1_next    = t1_eff;
        pend_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = lvl_m2[AW-1:0];
        ram_wdata  = t1_eff;
        ram_raddr  = lvl_m3[AW-1:0];
        pop        = '0;

        if (take)
        begin
            if (req.req_type == REQ_START)
            begin
                if (is_full)
                begin
                    pop.valid  = 1'b1;
                    pop.status = STATUS_FULL;
                end
                else
                begin
                    t0_next.func  = req.func_id;
                    t0_next.start = req.timestamp;
                    t0_next.child = '0;
                    t1_next       = t0_reg;
                    ram_we        = (level_reg >= LW'(2));
                    level_next    = level_reg + LW'(1);
                end
            end
            else if (is_empty)
            begin
                pop.valid  = 1'b1;
                pop.status = STATUS_EMPTY;
            end
            else
            begin
                pop.valid     = 1'b1;
                pop.status    = STATUS_OK;
                pop.fid       = t0_reg.func;
                pop.span      = span;
                pop.excl      = excl;
                // parent becomes top and collects the child span
                t0_next       = t1_eff;
                t0_next.child = sat_add(t1_eff.child, span);
                pend_next     = (level_reg >= LW'(3));
                level_next    = level_reg - LW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg <= t0_next;
        t1_reg <= t1_next;
    end

    cset_ram #(
        .WIDTH ($bits(stk_entry_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> hdl/cset_total.sv
`default_nettype none

module cset_total
    import cset_pkg::*;
#(
    parameter int MAX_FUNCS = DEF_MAX_FUNCS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire pop_t pop,
    output logic      clearing,
    output logic      res_valid,
    output cset_out_t res
);

    localparam int TW = $clog2(MAX_FUNCS);

    logic [TW+7:0] fid_wide;
    logic [TW-1:0] pop_idx;
    logic          pop_hit;

    logic          s2_valid_reg;
    pop_t          s2_reg;
    logic          s2_hit_reg;
    logic [TW-1:0] s2_idx_reg;

    logic          fwd_valid_reg;
    logic [TW-1:0] fwd_idx_reg;
    logic [31:0]   fwd_data_reg;

    logic          clr_active_reg;
    logic [TW-1:0] clr_idx_reg;

    logic [31:0]   base;
    logic [31:0]   sum;
    logic          upd_we;

    logic          ram_we;
    logic [TW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    always_comb
    begin
        fid_wide = (TW + 8)'(pop.fid);
        pop_idx  = fid_wide[TW-1:0];
        pop_hit  = ({24'd0, pop.fid} < 32'(MAX_FUNCS));

        // write issued in the cycle of this entry's read is not in the ram data
        base   = (fwd_valid_reg && (fwd_idx_reg == s2_idx_reg)) ? fwd_data_reg : ram_rdata;
        sum    = sat_add(base, s2_reg.excl);
        upd_we = s2_valid_reg && (s2_reg.status == STATUS_OK) && s2_hit_reg;

        ram_we    = clr_active_reg || upd_we;
        ram_waddr = clr_active_reg ? clr_idx_reg : s2_idx_reg;
        ram_wdata = clr_active_reg ? 32'd0 : sum;

        clearing  = clr_active_reg;
        res_valid = s2_valid_reg;
        res.ended_id        = s2_reg.fid;
        res.span_ticks      = s2_reg.span;
        res.exclusive_ticks = s2_reg.excl;
        res.running_total   = upd_we ? sum : 32'd0;
        res.status          = s2_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            s2_valid_reg  <= pop.valid;
            fwd_valid_reg <= upd_we;
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + TW'(1);
                if (clr_idx_reg == TW'(MAX_FUNCS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg       <= pop;
        s2_hit_reg   <= pop_hit;
        s2_idx_reg   <= pop_idx;
        fwd_idx_reg  <= s2_idx_reg;
        fwd_data_reg <= sum;
    end

    cset_ram #(
        .WIDTH (32),
        .DEPTH (MAX_FUNCS)
    ) u_total_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pop_idx),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> hdl/cset_outq.sv
`default_nettype none

module cset_outq
    import cset_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire cset_out_t                  push_data,
    input  wire logic                       stall,
    output logic                            valid,
    output cset_out_t                       data,
    output logic [$clog2(DEPTH + 1)-1:0]    count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cset_out_t     entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_pop;

    always_comb
    begin
        valid  = (cnt_reg != '0);
        data   = entry_reg[rd_ptr_reg];
        count  = cnt_reg;
        do_pop = valid && !stall;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/call_stack_exclusive_time.sv
`default_nettype none

// call-trace profiler: start events push (id, time, zero child time), end events pop the top,
// give span, exclusive time and the function's saturating running total, one result per end
// or per error (end on empty stack, start on full stack). one event is taken every clock while
// req_stall is low; a result passes the s2 register and the result queue before it leaves.
// the top two stack entries sit in registers and the rest in a ram that is read ahead, so pops
// run back to back; the totals ram is read at the event and written in the next cycle with a
// bypass for back-to-back hits. after reset the totals ram is zeroed one entry a cycle, req_stall
// high. a three-entry result queue keeps events flowing while the result side stalls, till full.
module call_stack_exclusive_time
    import cset_pkg::*;
#(
    parameter int MAX_FUNCS   = DEF_MAX_FUNCS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire cset_in_t  req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output cset_out_t      rsp
);

    localparam int QCW = $clog2(OUTQ_DEPTH + 1);

    logic           take;
    pop_t           pop;
    logic           clearing;
    logic           res_valid;
    cset_out_t      res;
    logic [QCW-1:0] q_count;
    logic [QCW:0]   occ;

    always_comb
    begin
        occ       = (QCW + 1)'(q_count) + (QCW + 1)'(res_valid);
        req_stall = clearing || (occ >= (QCW + 1)'(OUTQ_DEPTH));
        take      = req_valid && !req_stall;
    end

    cset_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .req   (req),
        .pop   (pop)
    );

    cset_total #(
        .MAX_FUNCS (MAX_FUNCS)
    ) u_total (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res       (res)
    );

    cset_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .stall     (rsp_stall),
        .valid     (rsp_valid),
        .data      (rsp),
        .count     (q_count)
    );

endmodule

`default_nettype wire
